>>> sv/msf_pkg.sv
package msf_pkg;
	localparam int PROB_W = 17;
	localparam int ONE_Q16 = 65536;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT,
		ST_EVAL,
		ST_EMIT,
		ST_WAIT
	} core_state_t;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic              last;
	} in_item_t;
endpackage

>>> sv/marginal_sort_and_flatten.sv
// Sequence: the vector is loaded and bubble-sorted, then for each k a share
// divider computes floor(65536/k) and the squared error is evaluated;
// results are then emitted, held while the receiver stalls.
// Throughput: one vector at a time; the next is loaded once the last result
// is taken. The input queue holds two items while the core is busy.
// Reset: arst_n asynchronous active low clears the queue, counters and
// outputs; the probability store is not cleared.
module marginal_sort_and_flatten import msf_pkg::*; #(
	parameter int MAX_STATES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [16:0]       probability,
	input  logic              vector_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        state_index,
	output logic [16:0]       sorted_probability,
	output logic [16:0]       flattened_probability,
	output logic [6:0]        best_count,
	output logic              result_last
);
	logic q_valid, q_pop;
	in_item_t q_item;

	msf_front #(.QD(2)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_prob(probability), .in_last(vector_last),
		.q_valid, .q_pop, .q_item
	);

	msf_back #(.MAX_STATES(MAX_STATES)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid, .out_stall, .state_index, .sorted_probability,
		.flattened_probability, .best_count, .result_last
	);
endmodule

>>> sv/msf_front.sv
module msf_front import msf_pkg::*; #(
	parameter int QD = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PROB_W-1:0] in_prob,
	input  logic              in_last,
	output logic              q_valid,
	input  logic              q_pop,
	output in_item_t          q_item
);
	localparam int AW = (QD > 1) ? $clog2(QD) : 1;
	in_item_t mem_q [QD];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == (AW+1)'(QD));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{prob: in_prob, last: in_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(QD-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == AW'(QD-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

>>> sv/msf_back.sv
module msf_back import msf_pkg::*; #(
	parameter int MAX_STATES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  in_item_t          q_item,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        state_index,
	output logic [PROB_W-1:0] sorted_probability,
	output logic [PROB_W-1:0] flattened_probability,
	output logic [6:0]        best_count,
	output logic              result_last
);
	localparam int AW = $clog2(MAX_STATES);
	localparam int CW = $clog2(MAX_STATES + 1);
	localparam int EW = 2 * PROB_W + CW;

	core_state_t st_q, st_d;
	logic [PROB_W-1:0] prob_q [MAX_STATES];
	logic [5:0]        idx_q [MAX_STATES];
	logic [CW-1:0] n_q, i_q, j_q, k_q, bk_q;
	logic [EW-1:0] err_q, best_q;
	logic [PROB_W-1:0] share_q, bshare_q;
	// long division for floor(65536/k), one quotient bit a cycle
	logic [PROB_W-1:0] rem_q, quo_q;
	logic [4:0] dbit_q;
	logic [1:0] phase_q; // 0 divide, 1 accumulate

	logic sort_swap, sort_pass_end, sort_done;
	logic [CW-1:0] j_next;
	logic [PROB_W-1:0] pa, ps;
	logic [PROB_W-1:0] diff;
	logic [2*PROB_W-1:0] sq;
	logic [PROB_W:0] trial;
	logic [PROB_W-1:0] rem_sh;

	// odd/even-free bubble sort: j walks 0..n-2, swap if strictly less keeps stability
	assign j_next = j_q + 1'b1;
	assign sort_swap = (prob_q[j_q[AW-1:0]] < prob_q[j_next[AW-1:0]]);
	assign sort_pass_end = (j_next >= n_q - 1'b1);
	assign sort_done = (n_q < CW'(2)) || (sort_pass_end && i_q >= n_q - 1'b1);

	assign pa = prob_q[j_q[AW-1:0]];
	assign ps = (j_q < k_q) ? share_q : '0;
	assign diff = (pa >= ps) ? pa - ps : ps - pa;
	assign sq = diff * diff;

	assign rem_sh = {rem_q[PROB_W-2:0], (dbit_q == 5'd16)};
	assign trial = {1'b0, rem_sh} - {{(PROB_W+1-CW){1'b0}}, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_LOAD;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		case (st_q)
			ST_LOAD: begin
				q_pop = q_valid;
				if (q_valid && q_item.last) st_d = ST_SORT;
			end
			ST_SORT: if (sort_done) st_d = ST_EVAL;
			ST_EVAL: if (phase_q == 2'd1 && j_next >= n_q && k_q >= n_q) st_d = ST_EMIT;
			ST_EMIT: if (!out_stall || !out_valid) st_d = ST_WAIT;
			ST_WAIT: begin
				if (!out_stall && j_q >= n_q) st_d = ST_LOAD;
				else if (!out_stall) st_d = ST_EMIT;
			end
			default: st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_LOAD: if (q_valid && n_q < CW'(MAX_STATES)) begin
				prob_q[n_q[AW-1:0]] <= q_item.prob;
				idx_q[n_q[AW-1:0]] <= 6'(n_q);
			end
			ST_SORT: if (!sort_done && sort_swap) begin
				prob_q[j_q[AW-1:0]] <= prob_q[j_next[AW-1:0]];
				prob_q[j_next[AW-1:0]] <= prob_q[j_q[AW-1:0]];
				idx_q[j_q[AW-1:0]] <= idx_q[j_next[AW-1:0]];
				idx_q[j_next[AW-1:0]] <= idx_q[j_q[AW-1:0]];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			bk_q <= '0;
			phase_q <= '0;
			dbit_q <= '0;
			out_valid <= 1'b0;
			state_index <= '0;
			sorted_probability <= '0;
			flattened_probability <= '0;
			best_count <= '0;
			result_last <= 1'b0;
			err_q <= '0;
			best_q <= '0;
			share_q <= '0;
			bshare_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				ST_LOAD: if (q_valid) begin
					if (n_q < CW'(MAX_STATES)) n_q <= n_q + 1'b1;
					i_q <= '0;
					j_q <= '0;
					if (q_item.last) begin
						k_q <= CW'(1);
						phase_q <= 2'd0;
						dbit_q <= 5'd16;
						rem_q <= '0;
						quo_q <= '0;
					end
				end
				ST_SORT: if (!sort_done) begin
					if (sort_pass_end) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else j_q <= j_next;
				end else j_q <= '0;
				ST_EVAL: begin
					if (phase_q == 2'd0) begin
						// bits 16..0 of the dividend 65536
						if (!trial[PROB_W]) begin
							rem_q <= trial[PROB_W-1:0];
							quo_q <= {quo_q[PROB_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[PROB_W-2:0], 1'b0};
						end
						if (dbit_q == 5'd0) begin
							phase_q <= 2'd1;
							share_q <= (!trial[PROB_W]) ? {quo_q[PROB_W-2:0], 1'b1}
								: {quo_q[PROB_W-2:0], 1'b0};
							j_q <= '0;
							err_q <= '0;
						end
						dbit_q <= dbit_q - 1'b1;
					end else begin
						err_q <= err_q + EW'(sq);
						if (j_next >= n_q) begin
							if (k_q == CW'(1) || err_q + EW'(sq) < best_q) begin
								best_q <= err_q + EW'(sq);
								bk_q <= k_q;
								bshare_q <= share_q;
							end
							k_q <= k_q + 1'b1;
							phase_q <= 2'd0;
							dbit_q <= 5'd16;
							rem_q <= '0;
							quo_q <= '0;
							j_q <= '0;
						end else j_q <= j_next;
					end
				end
				ST_EMIT: if (!out_stall || !out_valid) begin
					out_valid <= 1'b1;
					state_index <= idx_q[j_q[AW-1:0]];
					sorted_probability <= prob_q[j_q[AW-1:0]];
					flattened_probability <= (j_q < bk_q) ? bshare_q : '0;
					best_count <= 7'(bk_q);
					result_last <= (j_next == n_q);
					j_q <= j_next;
				end
				ST_WAIT: if (!out_stall && j_q >= n_q) n_q <= '0;
				default: ;
			endcase
		end
	end
endmodule

>>> tb/sv/tb_marginal_sort_and_flatten.sv
module tb_marginal_sort_and_flatten;
	import msf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSTATES = 16;

	typedef struct {
		logic [5:0]  idx;
		logic [16:0] sprob;
		logic [16:0] flat;
		logic [6:0]  k;
		logic        last;
	} marginal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [16:0] probability = '0;
	logic vector_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] state_index;
	logic [16:0] sorted_probability;
	logic [16:0] flattened_probability;
	logic [6:0] best_count;
	logic result_last;

	marginal_sort_and_flatten #(.MAX_STATES(NSTATES)) u_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [16:0] held_prob [NSTATES];
	logic [5:0]  held_idx [NSTATES];
	int held_n = 0;
	marginal_t expected_marginals[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic longint unsigned sqdiff(input longint unsigned a, input longint unsigned b);
		longint unsigned d;
		d = (a >= b) ? a - b : b - a;
		return d * d;
	endfunction

	task automatic predict_flatten(input logic [16:0] p, input logic lst);
		logic [16:0] tp;
		logic [5:0] ti;
		int j;
		int best;
		longint unsigned err, best_err;
		logic [16:0] share;
		marginal_t m;
		if (held_n < NSTATES) begin
			held_prob[held_n] = p;
			held_idx[held_n] = 6'(held_n);
			held_n++;
		end
		if (!lst)
			return;
		for (int i = 1; i < held_n; i++) begin
			tp = held_prob[i];
			ti = held_idx[i];
			j = i;
			while (j > 0 && held_prob[j-1] < tp) begin
				held_prob[j] = held_prob[j-1];
				held_idx[j] = held_idx[j-1];
				j--;
			end
			held_prob[j] = tp;
			held_idx[j] = ti;
		end
		best = 1;
		best_err = 0;
		for (int k = 1; k <= held_n; k++) begin
			err = 0;
			for (int q = 0; q < held_n; q++)
				err += sqdiff(held_prob[q], (q < k) ? ONE_Q16 / k : 0);
			if (k == 1 || err < best_err) begin
				best_err = err;
				best = k;
			end
		end
		share = 17'(ONE_Q16 / best);
		for (int q = 0; q < held_n; q++) begin
			m.idx = held_idx[q];
			m.sprob = held_prob[q];
			m.flat = (q < best) ? share : '0;
			m.k = 7'(best);
			m.last = (q + 1 == held_n);
			expected_marginals.push_back(m);
		end
		held_n = 0;
	endtask

	task automatic send_prob(input logic [16:0] p, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		probability <= p;
		vector_last <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_flatten(p, lst);
	endtask

	// receiver stall
	always @(posedge clk)
		out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		marginal_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_marginals.size() == 0) begin
				report_mismatch("result with none expected");
			end else begin
				m = expected_marginals.pop_front();
				if (state_index !== m.idx)
					report_mismatch($sformatf("state_index %0d exp %0d", state_index, m.idx));
				if (sorted_probability !== m.sprob)
					report_mismatch($sformatf("sorted_probability %0d exp %0d",
						sorted_probability, m.sprob));
				if (flattened_probability !== m.flat)
					report_mismatch($sformatf("flattened_probability %0d exp %0d",
						flattened_probability, m.flat));
				if (best_count !== m.k)
					report_mismatch($sformatf("best_count %0d exp %0d", best_count, m.k));
				if (result_last !== m.last)
					report_mismatch($sformatf("result_last %0d exp %0d", result_last, m.last));
			end
		end
	end

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_marginals.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_vector(input int n);
		int mode;
		mode = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: send_prob(17'($urandom_range(65536)), i == n - 1);
				1: send_prob(17'(ONE_Q16 / n + $urandom_range(3) - 1), i == n - 1);
				2: send_prob((i < 2) ? 17'd32768 : 17'($urandom_range(500)), i == n - 1);
				default: send_prob(17'($urandom_range(131071)), i == n - 1);
			endcase
		end
	endtask

	task automatic test_directed;
		send_prob(17'd65536, 1'b1);
		send_prob(17'd0, 1'b1);
		send_prob(17'h1FFFF, 1'b0);
		send_prob(17'd0, 1'b1);
		// ties keep input order
		send_prob(17'd21845, 1'b0);
		send_prob(17'd21845, 1'b0);
		send_prob(17'd21845, 1'b1);
		send_prob(17'd16384, 1'b0);
		send_prob(17'd49152, 1'b1);
		drain();
		// overflow: extra items dropped, dropped last still ends vector
		for (int i = 0; i < NSTATES + 2; i++)
			send_prob(17'(4096 + i), i == NSTATES + 1);
		drain();
	endtask

	task automatic test_random(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(NSTATES + 3, 1) : $urandom_range(6, 1);
			send_vector(n);
			sent += n;
		end
		drain();
	endtask

	task automatic test_backpressure;
		int cnt;
		hold_recv = 1;
		fork
			begin
				cnt = 0;
				while (cnt < 1500) begin
					@(posedge clk);
					cnt++;
				end
				hold_recv = 0;
			end
			for (int v = 0; v < 4; v++)
				send_vector(4);
		join
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 36;
		recv_idle_pct = 82;
		test_random(140);
		send_idle_pct = 82;
		recv_idle_pct = 36;
		test_random(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);
		test_backpressure();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
